### sv/ppm_pkg.sv
`default_nettype none
package ppm_pkg;

  // Defaults for the top-level parameters
  localparam int INDEX_BITS_DEF = 24;
  localparam int DIM_BITS_DEF   = 16;
  localparam int MAX_SAMPLE_DEF = 255;

  // Fixed field widths
  localparam int BYTE_W    = 8;
  localparam int DIM_OUT_W = 16;
  localparam int SAMPLE_W  = 8;
  localparam int PIX_W     = 24;
  localparam int ACC_W     = 10;

  // Result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_PIXEL  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Error codes
  localparam logic [1:0] ERR_NOT_PPM = 2'd0;
  localparam logic [1:0] ERR_DIM     = 2'd1;
  localparam logic [1:0] ERR_MAXVAL  = 2'd2;
  localparam logic [1:0] ERR_SAMPLE  = 2'd3;

  // Characters
  localparam logic [BYTE_W-1:0] CH_P     = 8'h50;
  localparam logic [BYTE_W-1:0] CH_3     = 8'h33;
  localparam logic [BYTE_W-1:0] CH_6     = 8'h36;
  localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic [1:0]           kind;
    logic [DIM_OUT_W-1:0] image_width;
    logic [DIM_OUT_W-1:0] image_height;
    logic [SAMPLE_W-1:0]  red;
    logic [SAMPLE_W-1:0]  green;
    logic [SAMPLE_W-1:0]  blue;
    logic [PIX_W-1:0]     pixel_index;
    logic [1:0]           error_code;
  } ppm_result_t;

  typedef struct packed {
    logic err_latched;
    logic in_data;
  } ppm_status_t;

  function automatic logic is_ws(input logic [BYTE_W-1:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_digit(input logic [BYTE_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage
`default_nettype wire

### sv/ppm_ifs.sv
`default_nettype none
interface ppm_byte_if;
  logic                         valid;
  logic                         ready;
  logic [ppm_pkg::BYTE_W-1:0]   data_byte;
  logic                         file_start;

  modport source (output valid, output data_byte, output file_start, input ready);
  modport sink   (input valid, input data_byte, input file_start, output ready);
endinterface

interface ppm_result_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    kind;
  logic [ppm_pkg::DIM_OUT_W-1:0] image_width;
  logic [ppm_pkg::DIM_OUT_W-1:0] image_height;
  logic [ppm_pkg::SAMPLE_W-1:0]  red;
  logic [ppm_pkg::SAMPLE_W-1:0]  green;
  logic [ppm_pkg::SAMPLE_W-1:0]  blue;
  logic [ppm_pkg::PIX_W-1:0]     pixel_index;
  logic [1:0]                    error_code;

  modport source (output valid, output kind, output image_width, output image_height,
                  output red, output green, output blue, output pixel_index,
                  output error_code, input ready);
  modport sink   (input valid, input kind, input image_width, input image_height,
                  input red, input green, input blue, input pixel_index,
                  input error_code, output ready);
endinterface
`default_nettype wire

### sv/ppm_core.sv
`default_nettype none
module ppm_core #(
  parameter int INDEX_BITS = ppm_pkg::INDEX_BITS_DEF,
  parameter int DIM_BITS   = ppm_pkg::DIM_BITS_DEF,
  parameter int MAX_SAMPLE = ppm_pkg::MAX_SAMPLE_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       step,
  input  wire logic [ppm_pkg::BYTE_W-1:0] data_byte,
  input  wire logic                       file_start,
  output ppm_pkg::ppm_result_t            res,
  output logic                            res_valid,
  output ppm_pkg::ppm_status_t            stat
);

  typedef enum logic [3:0] {
    PH_MAGIC, PH_TYPE, PH_MAGIC_LINE, PH_LINE_START, PH_COMMENT,
    PH_WIDTH, PH_HEIGHT, PH_MAXVAL, PH_DATA
  } phase_t;

  localparam int ACC_W = ppm_pkg::ACC_W;
  localparam logic [DIM_BITS-1:0] DIM_MAX = {DIM_BITS{1'b1}};
  localparam logic [ACC_W-1:0]    ACC_MAX = {ACC_W{1'b1}};

  phase_t                       phase,      phase_next;
  logic                         binary_mode, binary_mode_next;
  logic [ACC_W-1:0]             accum,      accum_next;
  logic                         started,    started_next;
  logic                         stopped,    stopped_next;
  logic [1:0]                   slot,       slot_next;
  logic [ppm_pkg::SAMPLE_W-1:0] held_red,   held_red_next;
  logic [ppm_pkg::SAMPLE_W-1:0] held_green, held_green_next;
  logic [INDEX_BITS-1:0]        pixel_count, pixel_count_next;
  logic [DIM_BITS-1:0]          width_reg,  width_reg_next;
  logic [DIM_BITS-1:0]          height_reg, height_reg_next;
  logic                         err_latched, err_latched_next;

  // Values after an optional restart at the head of a file
  phase_t                       cur_phase;
  logic                         cur_binary, cur_started, cur_stopped, cur_err;
  logic [ACC_W-1:0]             cur_accum;
  logic [1:0]                   cur_slot;
  logic [ppm_pkg::SAMPLE_W-1:0] cur_red, cur_green;
  logic [INDEX_BITS-1:0]        cur_pix;
  logic [DIM_BITS-1:0]          cur_width, cur_height;

  logic [3:0]          digit;
  logic [DIM_BITS+3:0] w_prod, h_prod;
  logic [ACC_W+3:0]    a_prod;
  logic [DIM_BITS-1:0] w_sat, h_sat;
  logic [ACC_W-1:0]    a_sat;
  logic                c_digit, c_ws;

  logic [ppm_pkg::PIX_W-1:0]     pix_out;
  logic [ppm_pkg::DIM_OUT_W-1:0] w_out, h_out;

  logic                         take;
  logic [ppm_pkg::SAMPLE_W-1:0] sample;
  logic                         emit;
  logic                         lead_in;

  assign cur_phase   = file_start ? PH_MAGIC : phase;
  assign cur_binary  = file_start ? 1'b0 : binary_mode;
  assign cur_accum   = file_start ? '0 : accum;
  assign cur_started = file_start ? 1'b0 : started;
  assign cur_stopped = file_start ? 1'b0 : stopped;
  assign cur_slot    = file_start ? 2'd0 : slot;
  assign cur_red     = file_start ? '0 : held_red;
  assign cur_green   = file_start ? '0 : held_green;
  assign cur_pix     = file_start ? '0 : pixel_count;
  assign cur_width   = file_start ? '0 : width_reg;
  assign cur_height  = file_start ? '0 : height_reg;
  assign cur_err     = file_start ? 1'b0 : err_latched;

  assign digit   = data_byte[3:0];
  assign c_digit = ppm_pkg::is_digit(data_byte);
  assign c_ws    = ppm_pkg::is_ws(data_byte);

  // A line start that is no comment feeds the width field from zero
  assign lead_in = (cur_phase == PH_LINE_START);

  // Multiply by ten and add the digit, saturating
  always_comb begin
    logic [DIM_BITS+3:0] wv;
    logic [DIM_BITS+3:0] hv;
    logic [ACC_W+3:0]    av;
    wv = {4'b0, (lead_in ? {DIM_BITS{1'b0}} : cur_width)};
    hv = {4'b0, cur_height};
    av = {4'b0, cur_accum};
    w_prod = (wv << 3) + (wv << 1) + (DIM_BITS+4)'(digit);
    h_prod = (hv << 3) + (hv << 1) + (DIM_BITS+4)'(digit);
    a_prod = (av << 3) + (av << 1) + (ACC_W+4)'(digit);
    w_sat  = (w_prod > {4'b0, DIM_MAX}) ? DIM_MAX : w_prod[DIM_BITS-1:0];
    h_sat  = (h_prod > {4'b0, DIM_MAX}) ? DIM_MAX : h_prod[DIM_BITS-1:0];
    a_sat  = (a_prod > {4'b0, ACC_MAX}) ? ACC_MAX : a_prod[ACC_W-1:0];
  end

  if (INDEX_BITS >= ppm_pkg::PIX_W) begin : g_pix_trunc
    assign pix_out = cur_pix[ppm_pkg::PIX_W-1:0];
  end else begin : g_pix_ext
    assign pix_out = {{(ppm_pkg::PIX_W-INDEX_BITS){1'b0}}, cur_pix};
  end

  if (DIM_BITS >= ppm_pkg::DIM_OUT_W) begin : g_dim_trunc
    assign w_out = cur_width[ppm_pkg::DIM_OUT_W-1:0];
    assign h_out = cur_height[ppm_pkg::DIM_OUT_W-1:0];
  end else begin : g_dim_ext
    assign w_out = {{(ppm_pkg::DIM_OUT_W-DIM_BITS){1'b0}}, cur_width};
    assign h_out = {{(ppm_pkg::DIM_OUT_W-DIM_BITS){1'b0}}, cur_height};
  end

  always_comb begin
    phase_next       = cur_phase;
    binary_mode_next = cur_binary;
    accum_next       = cur_accum;
    started_next     = cur_started;
    stopped_next     = cur_stopped;
    slot_next        = cur_slot;
    held_red_next    = cur_red;
    held_green_next  = cur_green;
    pixel_count_next = cur_pix;
    width_reg_next   = cur_width;
    height_reg_next  = cur_height;
    err_latched_next = cur_err;
    res              = '0;
    emit             = 1'b0;
    take             = 1'b0;
    sample           = '0;

    if (!cur_err) begin
      unique case (cur_phase)
        PH_MAGIC: begin
          if (data_byte != ppm_pkg::CH_P) begin
            emit = 1'b1;
            res.kind = ppm_pkg::KIND_ERROR;
            res.error_code = ppm_pkg::ERR_NOT_PPM;
          end else begin
            phase_next = PH_TYPE;
          end
        end
        PH_TYPE: begin
          if (data_byte == ppm_pkg::CH_3 || data_byte == ppm_pkg::CH_6) begin
            binary_mode_next = (data_byte == ppm_pkg::CH_6);
            phase_next = PH_MAGIC_LINE;
          end else begin
            emit = 1'b1;
            res.kind = ppm_pkg::KIND_ERROR;
            res.error_code = ppm_pkg::ERR_NOT_PPM;
          end
        end
        PH_MAGIC_LINE, PH_COMMENT: begin
          if (data_byte == ppm_pkg::CH_LF) phase_next = PH_LINE_START;
        end
        PH_LINE_START, PH_WIDTH: begin
          if (lead_in && data_byte == ppm_pkg::CH_HASH) begin
            phase_next = PH_COMMENT;
          end else begin
            phase_next = PH_WIDTH;
            if (lead_in) begin
              started_next   = 1'b0;
              width_reg_next = '0;
            end
            if (c_digit) begin
              width_reg_next = w_sat;
              started_next   = 1'b1;
            end else if (c_ws) begin
              if (cur_started && !lead_in) begin
                started_next    = 1'b0;
                phase_next      = PH_HEIGHT;
                height_reg_next = '0;
              end
            end else begin
              emit = 1'b1;
              res.kind = ppm_pkg::KIND_ERROR;
              res.error_code = ppm_pkg::ERR_DIM;
            end
          end
        end
        PH_HEIGHT: begin
          if (c_digit) begin
            height_reg_next = h_sat;
            started_next    = 1'b1;
          end else if (c_ws) begin
            if (cur_started) begin
              started_next = 1'b0;
              phase_next   = PH_MAXVAL;
              accum_next   = '0;
            end
          end else begin
            emit = 1'b1;
            res.kind = ppm_pkg::KIND_ERROR;
            res.error_code = cur_started ? ppm_pkg::ERR_MAXVAL : ppm_pkg::ERR_DIM;
          end
        end
        PH_MAXVAL: begin
          if (c_digit) begin
            accum_next   = a_sat;
            started_next = 1'b1;
          end else if (!cur_started) begin
            if (!c_ws) begin
              emit = 1'b1;
              res.kind = ppm_pkg::KIND_ERROR;
              res.error_code = ppm_pkg::ERR_MAXVAL;
            end
          end else if (cur_accum != ACC_W'(MAX_SAMPLE)) begin
            emit = 1'b1;
            res.kind = ppm_pkg::KIND_ERROR;
            res.error_code = ppm_pkg::ERR_MAXVAL;
          end else begin
            phase_next       = PH_DATA;
            accum_next       = '0;
            started_next     = 1'b0;
            stopped_next     = 1'b0;
            slot_next        = 2'd0;
            pixel_count_next = '0;
            emit             = 1'b1;
            res.kind         = ppm_pkg::KIND_HEADER;
            res.image_width  = w_out;
            res.image_height = h_out;
          end
        end
        PH_DATA: begin
          if (cur_binary) begin
            take   = 1'b1;
            sample = data_byte;
          end else if (c_ws) begin
            if (cur_started) begin
              accum_next   = '0;
              started_next = 1'b0;
              stopped_next = 1'b0;
              if (cur_accum > ACC_W'(MAX_SAMPLE)) begin
                emit = 1'b1;
                res.kind = ppm_pkg::KIND_ERROR;
                res.error_code = ppm_pkg::ERR_SAMPLE;
              end else begin
                take   = 1'b1;
                sample = cur_accum[ppm_pkg::SAMPLE_W-1:0];
              end
            end
          end else begin
            started_next = 1'b1;
            if (!cur_stopped && c_digit) accum_next = a_sat;
            else stopped_next = 1'b1;
          end
        end
        default: begin
          phase_next = PH_MAGIC;
          emit = 1'b1;
          res.kind = ppm_pkg::KIND_ERROR;
          res.error_code = ppm_pkg::ERR_NOT_PPM;
        end
      endcase

      // Group samples into a pixel; emit on blue
      if (take) begin
        case (cur_slot)
          2'd0: begin
            held_red_next = sample;
            slot_next     = 2'd1;
          end
          2'd1: begin
            held_green_next = sample;
            slot_next       = 2'd2;
          end
          default: begin
            slot_next        = 2'd0;
            emit             = 1'b1;
            res.kind         = ppm_pkg::KIND_PIXEL;
            res.red          = cur_red;
            res.green        = cur_green;
            res.blue         = sample;
            res.pixel_index  = pix_out;
            pixel_count_next = cur_pix + INDEX_BITS'(1);
          end
        endcase
      end

      if (emit && res.kind == ppm_pkg::KIND_ERROR) err_latched_next = 1'b1;
    end
  end

  assign res_valid = step && emit;

  assign stat.err_latched = err_latched;
  assign stat.in_data     = (phase == PH_DATA);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_MAGIC;
      binary_mode <= 1'b0;
      accum       <= '0;
      started     <= 1'b0;
      stopped     <= 1'b0;
      slot        <= 2'd0;
      held_red    <= '0;
      held_green  <= '0;
      pixel_count <= '0;
      width_reg   <= '0;
      height_reg  <= '0;
      err_latched <= 1'b0;
    end else if (step) begin
      phase       <= phase_next;
      binary_mode <= binary_mode_next;
      accum       <= accum_next;
      started     <= started_next;
      stopped     <= stopped_next;
      slot        <= slot_next;
      held_red    <= held_red_next;
      held_green  <= held_green_next;
      pixel_count <= pixel_count_next;
      width_reg   <= width_reg_next;
      height_reg  <= height_reg_next;
      err_latched <= err_latched_next;
    end
  end

endmodule
`default_nettype wire

### sv/ppm_out_stage.sv
`default_nettype none
module ppm_out_stage (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  res_valid,
  input  ppm_pkg::ppm_result_t       res,
  output logic                       space,
  ppm_result_if.source               result_ch
);

  logic                 valid;
  ppm_pkg::ppm_result_t data;

  // Free when empty or when the held beat leaves this cycle
  assign space = !valid || result_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (space) begin
      valid <= res_valid;
    end
    if (space && res_valid) data <= res;
  end

  assign result_ch.valid        = valid;
  assign result_ch.kind         = data.kind;
  assign result_ch.image_width  = data.image_width;
  assign result_ch.image_height = data.image_height;
  assign result_ch.red          = data.red;
  assign result_ch.green        = data.green;
  assign result_ch.blue         = data.blue;
  assign result_ch.pixel_index  = data.pixel_index;
  assign result_ch.error_code   = data.error_code;

endmodule
`default_nettype wire

### sv/ppm_stream_parser.sv
// Held bytes go through the parse logic in a single pass; results go into the output register.
// Throughput: one byte per cycle while the output has room; parse state updates once per byte.
// Backpressure: the input register refills while the output register drains.
// Reset: synchronous rst clears the parser to expect the magic letter and empties both registers.
// A byte flagged file_start restarts parsing before it is used; errors latch until then.
`default_nettype none
module ppm_stream_parser #(
  parameter int INDEX_BITS = ppm_pkg::INDEX_BITS_DEF,
  parameter int DIM_BITS   = ppm_pkg::DIM_BITS_DEF,
  parameter int MAX_SAMPLE = ppm_pkg::MAX_SAMPLE_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  ppm_byte_if.sink       byte_ch,
  ppm_result_if.source   result_ch
);

  // Input register: holds one byte beat in front of the parse logic
  logic                       in_q_valid;
  logic [ppm_pkg::BYTE_W-1:0] in_q_byte;
  logic                       in_q_start;

  logic                 space;   // output register can take a result this cycle
  logic                 step;    // the held byte goes through the parser
  logic                 res_valid;
  ppm_pkg::ppm_result_t res;
  ppm_pkg::ppm_status_t stat;

  // Advance the held byte whenever the result side has room; bytes that
  // cause no result simply drop out after updating the parse state.
  assign step          = in_q_valid && space;
  assign byte_ch.ready = !in_q_valid || space;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (byte_ch.valid && byte_ch.ready) begin
      in_q_valid <= 1'b1;
    end else if (step) begin
      in_q_valid <= 1'b0;
    end
    if (byte_ch.valid && byte_ch.ready) begin
      in_q_byte  <= byte_ch.data_byte;
      in_q_start <= byte_ch.file_start;
    end
  end

  // Header, dimension, sample and pixel grouping logic plus parse state
  ppm_core #(
    .INDEX_BITS (INDEX_BITS),
    .DIM_BITS   (DIM_BITS),
    .MAX_SAMPLE (MAX_SAMPLE)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .data_byte  (in_q_byte),
    .file_start (in_q_start),
    .res        (res),
    .res_valid  (res_valid),
    .stat       (stat)
  );

  // Result register toward the sink
  ppm_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .space     (space),
    .result_ch (result_ch)
  );

  // A latched error silences the parser until a new file starts
  a_err_silent: assert property (@(posedge clk) disable iff (rst)
    (step && !in_q_start && stat.err_latched) |-> !res_valid)
    else $error("result produced while error latched");

  // Pixels come only out of the sample phase
  a_pixel_phase: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.kind == ppm_pkg::KIND_PIXEL) |-> stat.in_data)
    else $error("pixel outside sample phase");

  // A held byte stays until it can advance
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_q_valid && !space) |=> in_q_valid)
    else $error("input register lost a byte");

  // An error result latches the error for the next byte
  a_err_latch: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.kind == ppm_pkg::KIND_ERROR) |=> stat.err_latched)
    else $error("error not latched");

endmodule
`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int          ITEMS       = 1400;
  localparam int          HOLD_CYCLES = 60;
  localparam int          DRAIN_LIMIT = 5000;
  localparam int unsigned DIM_MAX     = (1 << ppm_pkg::DIM_BITS_DEF) - 1;
  localparam int unsigned ACC_MAX     = (1 << ppm_pkg::ACC_W) - 1;
  localparam int unsigned PIX_MASK    = (1 << ppm_pkg::INDEX_BITS_DEF) - 1;
  localparam logic [ppm_pkg::BYTE_W-1:0] CH_VT = 8'h0B;
  localparam logic [ppm_pkg::BYTE_W-1:0] CH_FF = 8'h0C;

  // Parser phases of the expected-behavior tracker
  typedef enum logic [3:0] {
    PH_WAIT_P, PH_TYPE_DIGIT, PH_TYPE_LINE, PH_LINE_START, PH_COMMENT,
    PH_WIDTH, PH_HEIGHT, PH_MAXVAL, PH_PIXELS
  } parse_phase_e;

  // Ways a generated file can go wrong; FL_NONE is a clean file
  typedef enum int {
    FL_NONE, FL_MAGIC, FL_TYPE, FL_WIDTH_LEAD, FL_WIDTH_END, FL_HEIGHT_LEAD,
    FL_HEIGHT_END, FL_MAXVAL_LEAD, FL_MAXVAL_VALUE, FL_SAMPLE, FL_TRUNC, FL_NOISE
  } file_flaw_e;

  // Tracks the parse of the accepted byte stream, queues the results it
  // implies and matches them against what the block emits.
  class ppm_tracker;
    ppm_pkg::ppm_result_t pending_results[$];
    ppm_pkg::ppm_result_t outcome;
    int unsigned  beats_in, live_bytes, mismatches, headers_seen, pixels_seen, errors_seen;
    parse_phase_e phase;
    bit           raw_mode, started, stopped, err_hold;
    int unsigned  accum, width_acc, height_acc, pix_count;
    logic [1:0]   slot;
    logic [7:0]   held_r, held_g;

    function new();
      restart();
    endfunction

    static function bit blank_char(logic [7:0] c);
      return c == ppm_pkg::CH_SPACE || (c >= ppm_pkg::CH_TAB && c <= ppm_pkg::CH_CR);
    endfunction

    static function bit digit_char(logic [7:0] c);
      return c >= ppm_pkg::CH_ZERO && c <= ppm_pkg::CH_NINE;
    endfunction

    function int unsigned sat10(int unsigned v, int unsigned d, int unsigned top);
      if (v > (top - d) / 10) return top;
      return v * 10 + d;
    endfunction

    function void restart();
      phase = PH_WAIT_P;
      raw_mode = 0; started = 0; stopped = 0; err_hold = 0;
      accum = 0; width_acc = 0; height_acc = 0; pix_count = 0;
      slot = 0; held_r = 0; held_g = 0;
    endfunction

    function bit flag_error(logic [1:0] code);
      err_hold = 1;
      outcome.kind = ppm_pkg::KIND_ERROR;
      outcome.error_code = code;
      return 1'b1;
    endfunction

    function bit take_sample(logic [7:0] s);
      if (slot == 0) begin
        held_r = s; slot = 1; return 1'b0;
      end
      if (slot == 1) begin
        held_g = s; slot = 2; return 1'b0;
      end
      slot = 0;
      outcome.kind = ppm_pkg::KIND_PIXEL;
      outcome.red = held_r;
      outcome.green = held_g;
      outcome.blue = s;
      outcome.pixel_index = pix_count[ppm_pkg::PIX_W-1:0];
      pix_count = (pix_count + 1) & PIX_MASK;
      return 1'b1;
    endfunction

    function bit dim_byte(logic [7:0] c);
      bit on_w;
      on_w = (phase == PH_WIDTH);
      if (digit_char(c)) begin
        if (on_w) width_acc = sat10(width_acc, c - ppm_pkg::CH_ZERO, DIM_MAX);
        else height_acc = sat10(height_acc, c - ppm_pkg::CH_ZERO, DIM_MAX);
        started = 1;
        return 1'b0;
      end
      if (blank_char(c)) begin
        if (started) begin
          started = 0;
          if (on_w) begin
            phase = PH_HEIGHT; height_acc = 0;
          end else begin
            phase = PH_MAXVAL; accum = 0;
          end
        end
        return 1'b0;
      end
      if (started && !on_w) return flag_error(ppm_pkg::ERR_MAXVAL);
      return flag_error(ppm_pkg::ERR_DIM);
    endfunction

    function bit parse_byte(logic [7:0] c, bit fs);
      int unsigned v;
      outcome = '0;
      if (fs) restart();
      if (err_hold) return 1'b0;
      live_bytes++;
      case (phase)
        PH_WAIT_P: begin
          if (c != ppm_pkg::CH_P) return flag_error(ppm_pkg::ERR_NOT_PPM);
          phase = PH_TYPE_DIGIT;
        end
        PH_TYPE_DIGIT: begin
          if (c == ppm_pkg::CH_3) raw_mode = 0;
          else if (c == ppm_pkg::CH_6) raw_mode = 1;
          else return flag_error(ppm_pkg::ERR_NOT_PPM);
          phase = PH_TYPE_LINE;
        end
        PH_TYPE_LINE, PH_COMMENT: begin
          if (c == ppm_pkg::CH_LF) phase = PH_LINE_START;
        end
        PH_LINE_START: begin
          if (c == ppm_pkg::CH_HASH) begin
            phase = PH_COMMENT;
            return 1'b0;
          end
          phase = PH_WIDTH; started = 0; width_acc = 0;
          return dim_byte(c);
        end
        PH_WIDTH, PH_HEIGHT: return dim_byte(c);
        PH_MAXVAL: begin
          if (digit_char(c)) begin
            accum = sat10(accum, c - ppm_pkg::CH_ZERO, ACC_MAX);
            started = 1;
            return 1'b0;
          end
          if (!started) begin
            if (blank_char(c)) return 1'b0;
            return flag_error(ppm_pkg::ERR_MAXVAL);
          end
          if (accum != ppm_pkg::MAX_SAMPLE_DEF) return flag_error(ppm_pkg::ERR_MAXVAL);
          phase = PH_PIXELS;
          accum = 0; started = 0; stopped = 0; slot = 0; pix_count = 0;
          outcome.kind = ppm_pkg::KIND_HEADER;
          outcome.image_width = width_acc[ppm_pkg::DIM_OUT_W-1:0];
          outcome.image_height = height_acc[ppm_pkg::DIM_OUT_W-1:0];
          return 1'b1;
        end
        PH_PIXELS: begin
          if (raw_mode) return take_sample(c);
          if (blank_char(c)) begin
            if (!started) return 1'b0;
            v = accum;
            accum = 0; started = 0; stopped = 0;
            if (v > ppm_pkg::MAX_SAMPLE_DEF) return flag_error(ppm_pkg::ERR_SAMPLE);
            return take_sample(v[7:0]);
          end
          started = 1;
          if (!stopped && digit_char(c)) accum = sat10(accum, c - ppm_pkg::CH_ZERO, ACC_MAX);
          else stopped = 1;
        end
        default: begin
          phase = PH_WAIT_P;
          return flag_error(ppm_pkg::ERR_NOT_PPM);
        end
      endcase
      return 1'b0;
    endfunction

    // Note an accepted byte beat and queue the result it causes, if any
    function void note_byte(logic [7:0] c, bit fs);
      beats_in++;
      if (parse_byte(c, fs)) pending_results.push_back(outcome);
    endfunction

    function string show(ppm_pkg::ppm_result_t r);
      return $sformatf("kind=%0d w=%0d h=%0d rgb=%02h/%02h/%02h idx=%0d err=%0d",
                       r.kind, r.image_width, r.image_height, r.red, r.green, r.blue,
                       r.pixel_index, r.error_code);
    endfunction

    // Check one accepted result beat against the oldest pending result
    function void check_result(ppm_pkg::ppm_result_t got);
      ppm_pkg::ppm_result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %s", show(got));
        return;
      end
      want = pending_results.pop_front();
      if (got.kind !== want.kind || got.image_width !== want.image_width ||
          got.image_height !== want.image_height || got.red !== want.red ||
          got.green !== want.green || got.blue !== want.blue ||
          got.pixel_index !== want.pixel_index || got.error_code !== want.error_code) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch at %0t: expected %s", $realtime, show(want));
          $display("                actual   %s", show(got));
        end
      end
      if (want.kind == ppm_pkg::KIND_HEADER) headers_seen++;
      else if (want.kind == ppm_pkg::KIND_PIXEL) pixels_seen++;
      else errors_seen++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  ppm_byte_if   byte_bus();
  ppm_result_if result_bus();

  ppm_stream_parser dut (
    .clk       (clk),
    .rst       (rst),
    .byte_ch   (byte_bus),
    .result_ch (result_bus)
  );

  always #6 clk = ~clk;

  ppm_tracker  tracker = new();
  logic [7:0]  file_bytes[$];
  bit          calm;      // no idling on either side once set
  bit          hold_req;  // ask the receiver for one long hold-off
  int          files_sent;

  // ---------------------------------------------------------------------------
  // Byte generators
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] any_but(logic [7:0] x);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == x);
    return b;
  endfunction

  // Any byte that is neither a digit nor whitespace
  function automatic logic [7:0] odd_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (ppm_tracker::blank_char(b) || ppm_tracker::digit_char(b));
    return b;
  endfunction

  // Sample byte biased toward the extremes
  function automatic logic [7:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic put_blank();
    case ($urandom_range(0, 5))
      0: file_bytes.push_back(ppm_pkg::CH_SPACE);
      1: file_bytes.push_back(ppm_pkg::CH_TAB);
      2: file_bytes.push_back(ppm_pkg::CH_LF);
      3: file_bytes.push_back(CH_VT);
      4: file_bytes.push_back(CH_FF);
      default: file_bytes.push_back(ppm_pkg::CH_CR);
    endcase
  endtask

  task automatic put_text(string s);
    foreach (s[i]) file_bytes.push_back(s[i]);
  endtask

  // Decimal digits of v, now and then with leading zeros
  task automatic put_number(int unsigned v);
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 2)) file_bytes.push_back(ppm_pkg::CH_ZERO);
    put_text($sformatf("%0d", v));
  endtask

  function automatic int unsigned dim_value();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 99999);
      1: return $urandom_range(65535, 9999999);  // saturates
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  // Width or height: optional blanks, an optional bad lead, digits, terminator
  task automatic put_dim(bit bad_lead, bit bad_end);
    repeat ($urandom_range(0, 2)) put_blank();
    if (bad_lead) file_bytes.push_back(odd_byte());
    put_number(dim_value());
    if (bad_end) file_bytes.push_back(odd_byte());
    else repeat ($urandom_range(1, 2)) put_blank();
  endtask

  // One P3 sample token; odd tokens carry signs or junk around the digits
  task automatic put_token(int unsigned v);
    case ($urandom_range(0, 11))
      0: begin
        file_bytes.push_back(odd_byte());
        put_number(v);
      end
      1: begin
        put_number(v);
        file_bytes.push_back(odd_byte());
        put_number($urandom_range(0, 999));
      end
      default: put_number(v);
    endcase
  endtask

  // Build one file into file_bytes; a filled file is a clean P6 with many pixels
  task automatic build_file(bit filled);
    file_flaw_e flaw;
    bit         raw;
    int         npix, nsamp, bad_at;
    file_bytes.delete();
    raw = filled || ($urandom_range(0, 1) == 1);
    if (filled || $urandom_range(0, 9) < 6) flaw = FL_NONE;
    else flaw = file_flaw_e'($urandom_range(int'(FL_MAGIC), int'(FL_NOISE)));
    if (flaw == FL_SAMPLE) raw = 0;

    if (flaw == FL_NOISE) begin
      repeat ($urandom_range(2, 10)) file_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end

    // magic line, then comment lines
    file_bytes.push_back(flaw == FL_MAGIC ? any_but(ppm_pkg::CH_P) : ppm_pkg::CH_P);
    if (flaw == FL_TYPE) begin
      do file_bytes.push_back(any_but(ppm_pkg::CH_3)); while (file_bytes[$] == ppm_pkg::CH_6);
    end else begin
      file_bytes.push_back(raw ? ppm_pkg::CH_6 : ppm_pkg::CH_3);
    end
    repeat ($urandom_range(0, 3)) file_bytes.push_back(any_but(ppm_pkg::CH_LF));
    file_bytes.push_back(ppm_pkg::CH_LF);
    repeat ($urandom_range(0, 2)) begin
      file_bytes.push_back(ppm_pkg::CH_HASH);
      repeat ($urandom_range(0, 4)) file_bytes.push_back(any_but(ppm_pkg::CH_LF));
      file_bytes.push_back(ppm_pkg::CH_LF);
    end

    put_dim(flaw == FL_WIDTH_LEAD, flaw == FL_WIDTH_END);
    put_dim(flaw == FL_HEIGHT_LEAD, flaw == FL_HEIGHT_END);

    // maxval and the single byte that ends it
    repeat ($urandom_range(0, 2)) put_blank();
    if (flaw == FL_MAXVAL_LEAD) file_bytes.push_back(odd_byte());
    if (flaw == FL_MAXVAL_VALUE) begin
      case ($urandom_range(0, 2))
        0: put_number($urandom_range(0, 254));
        1: put_number($urandom_range(256, 1023));
        default: put_number($urandom_range(1024, 999999));
      endcase
    end else begin
      put_number(ppm_pkg::MAX_SAMPLE_DEF);
    end
    if ($urandom_range(0, 3) == 0) file_bytes.push_back(odd_byte());
    else put_blank();

    // pixel data
    if (filled) npix = 24;
    else if ($urandom_range(0, 9) == 0) npix = $urandom_range(10, 30);
    else npix = $urandom_range(0, 6);
    nsamp = 3 * npix;
    if (raw) begin
      if (flaw == FL_TRUNC) nsamp = (nsamp == 0) ? 1 : nsamp - $urandom_range(1, 2);
      repeat (nsamp) file_bytes.push_back(pick_sample());
    end else begin
      if (nsamp == 0 && (flaw == FL_TRUNC || flaw == FL_SAMPLE)) nsamp = 1;
      bad_at = (flaw == FL_SAMPLE) ? $urandom_range(0, nsamp - 1) : -1;
      repeat ($urandom_range(0, 1)) put_blank();
      for (int k = 0; k < nsamp; k++) begin
        if (k == bad_at) put_number($urandom_range(256, 99999));
        else put_token(pick_sample());
        // drop the trailing blank of a truncated file: that token never lands
        if (!(flaw == FL_TRUNC && k == nsamp - 1)) repeat ($urandom_range(1, 3)) put_blank();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender: offer file_bytes one beat at a time; mark the first as file start
  // and, rarely, a byte in the middle too.
  // ---------------------------------------------------------------------------
  task automatic send_file();
    bit fs;
    foreach (file_bytes[i]) begin
      fs = (i == 0) || ($urandom_range(0, 249) == 0);
      // now and then an idle burst before this beat
      if (!calm && $urandom_range(0, 5) == 0) begin
        byte_bus.valid <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      byte_bus.valid      <= 1'b1;
      byte_bus.data_byte  <= file_bytes[i];
      byte_bus.file_start <= fs;
      do @(posedge clk); while (!byte_bus.ready);
      tracker.note_byte(file_bytes[i], fs);
    end
  endtask

  // Drop valid and hold until the block has delivered every pending result
  task automatic drain_results();
    byte_bus.valid <= 1'b0;
    do @(posedge clk); while (tracker.pending_results.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int settle;
    rst                 <= 1'b1;
    byte_bus.valid      <= 1'b0;
    byte_bus.data_byte  <= '0;
    byte_bus.file_start <= 1'b0;
    calm = 0;
    hold_req = 0;
    files_sent = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: a minimal P6 image with extreme and whitespace samples
    file_bytes.delete();
    put_text("P6\n1 1 255\n");
    file_bytes.push_back(8'h00);
    file_bytes.push_back(8'hFF);
    file_bytes.push_back(ppm_pkg::CH_SPACE);
    send_file();
    // bad type digit, then a missing magic letter
    file_bytes.delete();
    put_text("P5");
    send_file();
    file_bytes.delete();
    put_text("x");
    send_file();
    // a sign where the width should start
    file_bytes.delete();
    put_text("P3\n+");
    send_file();
    files_sent = 4;

    // Random files until enough byte beats have gone in
    while (tracker.beats_in < ITEMS) begin
      files_sent++;
      calm = tracker.beats_in > (ITEMS * 4) / 5;
      if (files_sent == 8) begin
        // long receiver hold-off while a large clean image streams in
        hold_req = 1;
        build_file(1);
      end else begin
        build_file(0);
      end
      send_file();
      if (files_sent == 20 || files_sent == 45) drain_results();
    end

    // Wind down: wait for the tail of results
    byte_bus.valid <= 1'b0;
    settle = 0;
    while (tracker.pending_results.size() != 0 && settle < DRAIN_LIMIT) begin
      @(posedge clk);
      settle++;
    end
    repeat (8) @(posedge clk);
    if (tracker.pending_results.size() != 0) begin
      $display("%0d expected results never arrived", tracker.pending_results.size());
      tracker.mismatches += tracker.pending_results.size();
    end

    $display("run: %0d files, %0d byte beats, %0d parsed; seen %0d headers, %0d pixels, %0d errors",
             files_sent, tracker.beats_in, tracker.live_bytes, tracker.headers_seen,
             tracker.pixels_seen, tracker.errors_seen);
    $display("mismatch count: %0d", tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: check each accepted result beat, stall in short random bursts,
  // and honor one long hold-off counted here.
  // ---------------------------------------------------------------------------
  initial begin
    int                   gap_left;
    int                   hold_left;
    ppm_pkg::ppm_result_t got;
    gap_left = 0;
    hold_left = 0;
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_bus.valid && result_bus.ready) begin
        got = {result_bus.kind, result_bus.image_width, result_bus.image_height,
               result_bus.red, result_bus.green, result_bus.blue,
               result_bus.pixel_index, result_bus.error_code};
        tracker.check_result(got);
      end
      if (hold_req) begin
        hold_req = 0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_bus.ready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        result_bus.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        gap_left = $urandom_range(1, 3) - 1;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= 1'b1;
      end
    end
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #3_000_000;
    $display("timeout: run did not finish");
    $display("CHECK FAILED");
    $finish;
  end

endmodule
